@@ sv/bba_pkg.sv @@
// Package for the buddy block allocator: field widths, command and status
// codes, and the counter update struct. No dependencies.
package bba_pkg;

  localparam int ORDER_W = 4;
  localparam int ADDR_W  = 10;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_NOSPACE = 1'b1;

  // One update of the per-order free counters.
  typedef struct packed {
    logic               inc;
    logic               dec;
    logic [ORDER_W-1:0] order;
  } cnt_op_t;

endpackage

@@ sv/bba_map_ram.sv @@
// Free-map memory: one write port, one read port, registered read data.
// No dependencies.
module bba_map_ram #(
  parameter int AW = 6,
  parameter int W  = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/bba_order_cnt.sv @@
// Per-order free block counters and the search for the lowest order at or
// above a request that holds a free block. Depends on bba_pkg.
module bba_order_cnt
  import bba_pkg::*;
#(
  parameter int NUM_ORDERS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cnt_op_t                       op,
  input  logic [ORDER_W-1:0]            req_order,
  output logic                          found,
  output logic [$clog2(NUM_ORDERS)-1:0] found_order
);

  localparam int OW  = $clog2(NUM_ORDERS);
  localparam int TOP = NUM_ORDERS - 1;

  logic [NUM_ORDERS-1:0] cnt [NUM_ORDERS];
  logic [OW-1:0]         idx;

  assign idx = op.order[OW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
        cnt[i] <= (i == TOP) ? NUM_ORDERS'(1) : '0;
      end
    end else if (op.inc) begin
      cnt[idx] <= cnt[idx] + NUM_ORDERS'(1);
    end else if (op.dec) begin
      cnt[idx] <= cnt[idx] - NUM_ORDERS'(1);
    end
  end

  always_comb begin
    found       = 1'b0;
    found_order = '0;
    for (int j = NUM_ORDERS - 1; j >= 0; j--) begin
      if ((cnt[j] != '0) && (ORDER_W'(j) >= req_order)) begin
        found       = 1'b1;
        found_order = OW'(j);
      end
    end
  end

endmodule

@@ sv/buddy_block_allocator.sv @@
// Buddy block allocator, top level: command FSM around the free-map memory
// and the per-order counters. Depends on bba_pkg, bba_map_ram, bba_order_cnt.
//
// Channels: command (cmd_valid/cmd_ready) carries command, block_order and
// block_address; response (rsp_valid/rsp_ready) carries granted_address and
// status. One response per command, in order.
// The free map holds one bit per block of every order, packed 32 to a word
// in a single-port-read memory; every map access is a read state (S_RD)
// followed by a modify/write state (S_EX), which together make one step.
// Allocate scans map words at the chosen order (up to POOL_UNITS/32 words
// at order 0), then splits one level per step down to the request; free
// checks its own bit, merges with free buddies one level per step, then
// marks the merged block free. Order out of range or no space skips the map.
// One command is worked at a time; cmd_ready is high only when idle and
// rises together with rsp_valid for the previous result.
// Reset: counters reset at once; the map is then swept one word per cycle
// (2^NUM_ORDERS/32 words, 64 at the default) leaving only the whole-pool
// block free. Commands are not taken during the sweep.
// Stall: a finished result sits in the response register; the FSM may go
// idle and take the next command, and holds its next result until the
// response register frees up.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_ORDERS = 11,
  parameter int POOL_UNITS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic               command,
  input  logic [ORDER_W-1:0] block_order,
  input  logic [ADDR_W-1:0]  block_address,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [ADDR_W-1:0]  granted_address,
  output logic               status
);

  localparam int N     = NUM_ORDERS;
  localparam int TOP   = N - 1;
  localparam int OW    = $clog2(N);
  localparam int UW    = N - 1;               // unit / block index width
  localparam int LG    = (N > 5) ? 5 : N - 1; // log2 of bits per map word
  localparam int W     = 1 << LG;
  localparam int AW    = N - LG;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_EX, S_DONE} state_t;
  typedef enum logic [2:0] {P_SCAN, P_SPLIT, P_OWN, P_BUDDY, P_MARK} phase_t;

  state_t              state;
  phase_t              phase;
  logic [OW-1:0]       k;
  logic [OW-1:0]       req;
  logic [UW-1:0]       blk;
  logic [AW-1:0]       scan_word;
  logic [AW-1:0]       clr_addr;
  logic [ADDR_W-1:0]   res_addr;
  logic                res_stat;

  // memory and counter hookups
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [W-1:0]        rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [W-1:0]        wr_data;
  cnt_op_t             cop;
  logic                found;
  logic [OW-1:0]       found_order;

  // node arithmetic: node = 2^(TOP-k) + block (1-based heap index)
  logic [N-1:0]        base;
  logic [N-1:0]        last_node;
  logic [AW-1:0]       last_word;
  logic [N-1:0]        sbase;
  logic [UW-1:0]       cur_blk;
  logic [N-1:0]        node;
  logic [AW-1:0]       node_word;
  logic [LG-1:0]       node_bit;
  logic                bit_cur;
  logic [W-1:0]        node_mask;

  // scan
  logic                hit;
  logic [LG-1:0]       hit_pos;
  logic [N-1:0]        hit_node;
  logic [UW-1:0]       hit_blk;

  // input decode
  logic [31:0]         addr_ext;
  logic [UW-1:0]       addr_u;
  logic                order_bad;

  bba_map_ram #(.AW(AW), .W(W)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bba_order_cnt #(.NUM_ORDERS(N)) u_cnt (
    .clk         (clk),
    .rst         (rst),
    .op          (cop),
    .req_order   (block_order),
    .found       (found),
    .found_order (found_order)
  );

  assign cmd_ready = (state == S_IDLE);
  assign order_bad = (block_order > ORDER_W'(TOP));
  assign addr_ext  = 32'(block_address) & 32'(POOL_UNITS - 1);
  assign addr_u    = addr_ext[UW-1:0];

  assign base      = {{(N-1){1'b0}}, 1'b1} << (OW'(TOP) - k);
  assign sbase     = {{(N-1){1'b0}}, 1'b1} << (OW'(TOP) - found_order);
  assign last_node = (base << 1) - N'(1);   // wraps to all ones at order 0
  assign last_word = last_node[N-1:LG];

  always_comb begin
    unique case (phase)
      P_SPLIT: cur_blk = blk | UW'(1);
      P_BUDDY: cur_blk = blk ^ UW'(1);
      default: cur_blk = blk;
    endcase
  end

  assign node      = base + N'(cur_blk);
  assign node_word = node[N-1:LG];
  assign node_bit  = node[LG-1:0];
  assign node_mask = W'(1) << node_bit;
  assign bit_cur   = rd_data[node_bit];

  // lowest free block of order k inside the scanned word
  always_comb begin
    logic [N-1:0] wn;
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = W - 1; j >= 0; j--) begin
      wn = {scan_word, LG'(j)};
      if (rd_data[j] && (wn >= base) && (wn <= last_node)) begin
        hit     = 1'b1;
        hit_pos = LG'(j);
      end
    end
  end

  assign hit_node = {scan_word, hit_pos};
  assign hit_blk  = UW'(hit_node - base);

  // memory and counter drive
  always_comb begin
    rd_en     = (state == S_RD);
    rd_addr   = (phase == P_SCAN) ? scan_word : node_word;
    wr_en     = 1'b0;
    wr_addr   = node_word;
    wr_data   = rd_data;
    cop.inc   = 1'b0;
    cop.dec   = 1'b0;
    cop.order = ORDER_W'(k);
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = (clr_addr == '0) ? W'(2) : '0;  // top block is node 1
    end else if (state == S_EX) begin
      unique case (phase)
        P_SCAN: begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_addr = scan_word;
            wr_data = rd_data & ~(W'(1) << hit_pos);
            cop.dec = 1'b1;
          end
        end
        P_SPLIT, P_MARK: begin
          if (!bit_cur) begin
            wr_en   = 1'b1;
            wr_data = rd_data | node_mask;
            cop.inc = 1'b1;
          end
        end
        P_BUDDY: begin
          if (bit_cur) begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~node_mask;
            cop.dec = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] sh;
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '1;
      rsp_valid <= 1'b0;
      phase     <= P_SCAN;
    end else begin
      // S_DONE posts its own rsp_valid
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr - AW'(1);
          if (clr_addr == '0) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            req      <= block_order[OW-1:0];
            res_addr <= '0;
            if (order_bad) begin
              k        <= block_order[OW-1:0];
              res_stat <= (command == CMD_ALLOC) ? STAT_NOSPACE : STAT_OK;
              state    <= S_DONE;
            end else if (command == CMD_ALLOC) begin
              if (!found) begin
                k        <= block_order[OW-1:0];
                res_stat <= STAT_NOSPACE;
                state    <= S_DONE;
              end else begin
                k         <= found_order;
                res_stat  <= STAT_OK;
                scan_word <= sbase[N-1:LG];
                phase     <= P_SCAN;
                state     <= S_RD;
              end
            end else begin
              k        <= block_order[OW-1:0];
              res_stat <= STAT_OK;
              blk      <= addr_u >> block_order;
              phase    <= P_OWN;
              state    <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          unique case (phase)
            P_SCAN: begin
              if (hit) begin
                if (k > req) begin
                  k     <= k - OW'(1);
                  blk   <= hit_blk << 1;
                  phase <= P_SPLIT;
                  state <= S_RD;
                end else begin
                  sh       = 32'(hit_blk) << req;
                  res_addr <= sh[ADDR_W-1:0];
                  state    <= S_DONE;
                end
              end else if (scan_word == last_word) begin
                res_stat <= STAT_NOSPACE;
                state    <= S_DONE;
              end else begin
                scan_word <= scan_word + AW'(1);
                state     <= S_RD;
              end
            end
            P_SPLIT: begin
              if (k > req) begin
                k     <= k - OW'(1);
                blk   <= blk << 1;
                state <= S_RD;
              end else begin
                sh       = 32'(blk) << req;
                res_addr <= sh[ADDR_W-1:0];
                state    <= S_DONE;
              end
            end
            P_OWN: begin
              if (bit_cur) begin
                state <= S_DONE;   // already free
              end else if (k == OW'(TOP)) begin
                phase <= P_MARK;
                state <= S_RD;
              end else begin
                phase <= P_BUDDY;
                state <= S_RD;
              end
            end
            P_BUDDY: begin
              state <= S_RD;
              if (bit_cur) begin
                k     <= k + OW'(1);
                blk   <= blk >> 1;
                phase <= (k + OW'(1) == OW'(TOP)) ? P_MARK : P_BUDDY;
              end else begin
                phase <= P_MARK;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        default: begin   // S_DONE: wait for a free response slot
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            granted_address <= res_addr;
            status          <= res_stat;
            state           <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ sv/bba_checker.sv @@
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator.
module bba_checker
  import bba_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [ADDR_W-1:0]  granted_address,
  input logic               status
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_address) && $stable(status))
    else $error("response changed while stalled");

  // no-space answers carry a zero address
  a_nospace_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STAT_NOSPACE) |-> granted_address == '0)
    else $error("no-space response with nonzero address");

  // map sweep follows reset
  a_sweep: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("command taken during map sweep");

  // one command in flight
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second command taken while busy");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
